>>> rtl/ccpi_pkg.sv
// package for the cross-coupled incremental pi pwm regulator
// field widths, reset values, register indexes and sequencer states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ccpi_pkg;

    // defaults for the top level parameters
    localparam int unsigned CHANNELS_DEF       = 6;
    localparam int unsigned PWM_FULL_SCALE_DEF = 100;
    localparam int unsigned DUTY_W_DEF         = 7;

    // fixed field widths
    localparam int unsigned CH_W       = 3;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned ERR_W      = 19;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned DRIVE_W    = 32;
    localparam int unsigned SUP_W      = 8;
    localparam int unsigned SLOW_W     = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // serial multiplier: per-step difference term and upper partial product
    localparam int unsigned DIFF_W = ERR_W + 1;
    localparam int unsigned PHI_W  = DIFF_W + 2;
    localparam int unsigned PROD_W = PHI_W + GAIN_W;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_ERROR_FAST_RST = 16'd4188;
    localparam logic [GAIN_W-1:0] GAIN_PREV_FAST_RST  = 16'd1266;
    localparam logic [GAIN_W-1:0] GAIN_ERROR_SLOW_RST = 16'd419;
    localparam logic [GAIN_W-1:0] GAIN_PREV_SLOW_RST  = 16'd127;
    localparam logic [SLOW_W-1:0] SLOW_FIRST_RST      = 3'd4;
    localparam logic [SUP_W-1:0]  SUPPLY_MAX_RST      = 8'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_ERROR_FAST = 3'd0,
        CFG_GAIN_PREV_FAST  = 3'd1,
        CFG_GAIN_ERROR_SLOW = 3'd2,
        CFG_GAIN_PREV_SLOW  = 3'd3,
        CFG_SLOW_FIRST      = 3'd4,
        CFG_SUPPLY_MAX      = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> rtl/ccpi_if.sv
// valid/ready channel interfaces: speed items, duty results, register writes
// depends on ccpi_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ccpi_in_if import ccpi_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            channel;
    logic signed [SPEED_W-1:0]  own_speed;
    logic signed [SPEED_W-1:0]  partner_speed;
    logic signed [SPEED_W-1:0]  reference_speed;

    modport source (output valid, channel, own_speed, partner_speed, reference_speed,
                    input ready);
    modport sink   (input valid, channel, own_speed, partner_speed, reference_speed,
                    output ready);
endinterface

interface ccpi_out_if import ccpi_pkg::*; #(
    parameter int unsigned DUTY_W = DUTY_W_DEF
) ();
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   duty_channel;
    logic [DUTY_W-1:0] duty;
    logic              clamped;

    modport source (output valid, duty_channel, duty, clamped, input ready);
    modport sink   (input valid, duty_channel, duty, clamped, output ready);
endinterface

interface ccpi_cfg_if import ccpi_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/cross_coupled_incremental_pi_pwm.sv
// cross-coupled incremental pi speed regulator with pwm duty output
// depends on ccpi_pkg and the channel interfaces in ccpi_if.sv
// Each transfer on i_in names a motor channel and brings its own speed, the partner
// motor's speed and the pair's reference speed; one duty result per item leaves on
// o_out. The error is reference - 2*own + partner; the channel's Q16.16 drive grows by
// gain_a*error - gain_b*previous_error (Q0.16 gains, slow pair from slow_channel_first
// upward) and saturates at 32 bits. Duty is drive*PWM_FULL_SCALE/(supply_max*65536),
// truncated toward zero and clamped to 0..PWM_FULL_SCALE with the clamped flag set when
// limited; supply_max of zero counts as one volt. A channel not below CHANNELS leaves
// the state alone and returns duty 0, clamped 0. One item is in work at a time; with
// W = bits of PWM_FULL_SCALE, a bit-serial multiplier walks the 16 gain bits, a
// shift-add scaler walks the W bits of the full scale, and a restoring divider yields
// 16 + W quotient bits, one per cycle. A bad channel skips the arithmetic and goes
// straight to the result. The next item is taken as soon as the result sits in the
// output register, even if o_out has not yet taken it. i_cfg is always ready; the user
// must write registers on i_cfg only while no item is in work, unchecked by the block.
`timescale 1ns / 1ps
`default_nettype none

module cross_coupled_incremental_pi_pwm import ccpi_pkg::*; #(
    parameter int unsigned CHANNELS       = CHANNELS_DEF,
    parameter int unsigned PWM_FULL_SCALE = PWM_FULL_SCALE_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ccpi_cfg_if.sink    i_cfg,
    ccpi_in_if.sink     i_in,
    ccpi_out_if.source  o_out
);

    // derived sizes
    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned PWM_W = $clog2(PWM_FULL_SCALE + 1);
    // scaled drive handed to the divider: floor(|drive| * full scale / 2^16)
    localparam int unsigned TQ_W  = DRIVE_W - 16 + PWM_W;
    localparam int unsigned CNT_W = $clog2(TQ_W);
    localparam int unsigned REM_W = SUP_W + 1;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_cnt;

    // configuration
    logic [GAIN_W-1:0]         r_gain_error_fast;
    logic [GAIN_W-1:0]         r_gain_prev_fast;
    logic [GAIN_W-1:0]         r_gain_error_slow;
    logic [GAIN_W-1:0]         r_gain_prev_slow;
    logic [SLOW_W-1:0]         r_slow_first;
    logic [SUP_W-1:0]          r_supply_max;

    // per-channel state
    logic signed [DRIVE_W-1:0] r_drive    [CHANNELS];
    logic signed [ERR_W-1:0]   r_prev_err [CHANNELS];

    // item in work
    logic                      r_bad;
    logic [CH_W-1:0]           r_ch;
    logic [IDX_W-1:0]          r_idx;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   r_pe;
    logic [GAIN_W-1:0]         r_ga;
    logic [GAIN_W-1:0]         r_gb;
    logic signed [PHI_W-1:0]   r_phi;
    logic [GAIN_W-1:0]         r_plo;
    logic                      r_neg;
    logic [DRIVE_W-1:0]        r_mag;
    logic [PWM_W-1:0]          r_pwm_bits;
    logic [DRIVE_W-1:0]        r_scl;
    logic [TQ_W-1:0]           r_dvd;
    logic [SUP_W-1:0]          r_rem;
    logic [SUP_W-1:0]          r_div;

    // output register
    logic                      r_out_valid;
    logic [CH_W-1:0]           r_out_ch;
    logic [PWM_W-1:0]          r_duty;
    logic                      r_clamped;

    // ------------------------------------------------------------------
    // combinational datapath
    // ------------------------------------------------------------------
    logic                      w_in_ready;
    logic                      w_in_xfer;
    logic                      w_ch_bad;
    logic                      w_slow;
    logic                      w_load;
    logic signed [ERR_W-1:0]   w_own_x, w_par_x, w_ref_x, w_err;

    logic signed [DIFF_W-1:0]  w_term_a, w_term_b, w_diff;
    logic signed [PHI_W-1:0]   w_pstep;

    logic signed [PROD_W-1:0]  w_prod, w_total;
    logic [PROD_W-DRIVE_W:0]   w_top;
    logic signed [DRIVE_W-1:0] w_sat;
    logic [DRIVE_W-1:0]        w_mag;

    logic [DRIVE_W:0]          w_sadd;
    logic [DRIVE_W-1:0]        w_shalf;

    logic [REM_W-1:0]          w_shift;
    logic                      w_ge;
    logic [REM_W-1:0]          w_rem_sub;

    logic [PWM_W-1:0]          w_duty;
    logic                      w_clamp;

    // error = reference - 2*own + partner, fits 19 bits signed
    assign w_own_x = ERR_W'(i_in.own_speed);
    assign w_par_x = ERR_W'(i_in.partner_speed);
    assign w_ref_x = ERR_W'(i_in.reference_speed);
    assign w_err   = w_ref_x - (w_own_x <<< 1) + w_par_x;

    assign w_in_xfer = i_in.valid && w_in_ready;
    assign w_ch_bad  = (32'(i_in.channel) >= CHANNELS);
    assign w_slow    = (i_in.channel >= r_slow_first);

    // one gain bit per step: add the signed term, shift the partial product right
    assign w_term_a = r_ga[0] ? DIFF_W'(r_err) : '0;
    assign w_term_b = r_gb[0] ? DIFF_W'(r_pe) : '0;
    assign w_diff   = w_term_a - w_term_b;
    assign w_pstep  = r_phi + PHI_W'(w_diff);

    // drive update and 32-bit saturation
    assign w_prod  = $signed({r_phi, r_plo});
    assign w_total = PROD_W'(r_drive[r_idx]) + w_prod;
    assign w_top   = w_total[PROD_W-1:DRIVE_W-1];
    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            w_sat = w_total[DRIVE_W-1:0];
        end else if (w_total[PROD_W-1]) begin
            w_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end
    // magnitude of the most negative drive still fits unsigned
    assign w_mag = w_sat[DRIVE_W-1] ? (~w_sat + 1'b1) : w_sat;

    // scaler: |drive| times full scale, one constant bit per step, low bits dropped
    assign w_sadd  = {1'b0, r_scl} + (r_pwm_bits[0] ? {1'b0, r_mag} : '0);
    assign w_shalf = w_sadd[DRIVE_W:1];

    // restoring divide by the supply, one quotient bit per step
    assign w_shift   = {r_rem, r_dvd[TQ_W-1]};
    assign w_ge      = (w_shift >= {1'b0, r_div});
    assign w_rem_sub = w_shift - {1'b0, r_div};

    // duty and clamp from the quotient
    always_comb begin
        w_duty  = '0;
        w_clamp = 1'b0;
        if (r_bad) begin
            w_duty  = '0;
            w_clamp = 1'b0;
        end else if (r_neg) begin
            // a negative quotient clamps; one that truncates to zero does not
            w_duty  = '0;
            w_clamp = |r_dvd;
        end else if (r_dvd > TQ_W'(PWM_FULL_SCALE)) begin
            w_duty  = PWM_W'(PWM_FULL_SCALE);
            w_clamp = 1'b1;
        end else begin
            w_duty  = r_dvd[PWM_W-1:0];
            w_clamp = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_in_ready = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = w_ch_bad ? ST_DONE : ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_cnt == '0) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (r_cnt == '0) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for room in the output register
                if (!r_out_valid || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_in.ready = w_in_ready;

    // ------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_error_fast <= GAIN_ERROR_FAST_RST;
            r_gain_prev_fast  <= GAIN_PREV_FAST_RST;
            r_gain_error_slow <= GAIN_ERROR_SLOW_RST;
            r_gain_prev_slow  <= GAIN_PREV_SLOW_RST;
            r_slow_first      <= SLOW_FIRST_RST;
            r_supply_max      <= SUPPLY_MAX_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_GAIN_ERROR_FAST: r_gain_error_fast <= i_cfg.data[GAIN_W-1:0];
                CFG_GAIN_PREV_FAST:  r_gain_prev_fast  <= i_cfg.data[GAIN_W-1:0];
                CFG_GAIN_ERROR_SLOW: r_gain_error_slow <= i_cfg.data[GAIN_W-1:0];
                CFG_GAIN_PREV_SLOW:  r_gain_prev_slow  <= i_cfg.data[GAIN_W-1:0];
                CFG_SLOW_FIRST:      r_slow_first      <= i_cfg.data[SLOW_W-1:0];
                CFG_SUPPLY_MAX:      r_supply_max      <= i_cfg.data[SUP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // per-channel state, read and written at the latched channel only
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_drive[i]    <= '0;
                r_prev_err[i] <= '0;
            end
        end else if (r_state == ST_SUM) begin
            r_drive[r_idx]    <= w_sat;
            r_prev_err[r_idx] <= r_err;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_bad <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_bad <= w_ch_bad;
                        r_ch  <= i_in.channel;
                        r_idx <= IDX_W'(i_in.channel);
                        r_err <= w_err;
                        r_ga  <= w_slow ? r_gain_error_slow : r_gain_error_fast;
                        r_gb  <= w_slow ? r_gain_prev_slow : r_gain_prev_fast;
                    end
                end
                ST_LOAD: begin
                    r_pe  <= r_prev_err[r_idx];
                    r_phi <= '0;
                    r_plo <= '0;
                    r_cnt <= CNT_W'(GAIN_W - 1);
                end
                ST_MUL: begin
                    r_phi <= w_pstep >>> 1;
                    r_plo <= {w_pstep[0], r_plo[GAIN_W-1:1]};
                    r_ga  <= r_ga >> 1;
                    r_gb  <= r_gb >> 1;
                    r_cnt <= r_cnt - 1'b1;
                end
                ST_SUM: begin
                    r_neg      <= w_sat[DRIVE_W-1];
                    r_mag      <= w_mag;
                    r_scl      <= '0;
                    r_pwm_bits <= PWM_W'(PWM_FULL_SCALE);
                    // zero supply counts as one volt
                    r_div      <= (r_supply_max == '0) ? SUP_W'(1) : r_supply_max;
                    r_cnt      <= CNT_W'(PWM_W - 1);
                end
                ST_SCALE: begin
                    r_scl      <= w_shalf;
                    r_pwm_bits <= r_pwm_bits >> 1;
                    if (r_cnt == '0) begin
                        // the remaining divide by 2^16 is a bit select
                        r_dvd <= w_shalf[16-PWM_W +: TQ_W];
                        r_rem <= '0;
                        r_cnt <= CNT_W'(TQ_W - 1);
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_DIV: begin
                    r_rem <= w_ge ? w_rem_sub[SUP_W-1:0] : w_shift[SUP_W-1:0];
                    r_dvd <= {r_dvd[TQ_W-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                end
                ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_ch  <= r_ch;
            r_duty    <= w_duty;
            r_clamped <= w_clamp;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.duty_channel = r_out_ch;
    assign o_out.duty         = r_duty;
    assign o_out.clamped      = r_clamped;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_div_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_div != '0) && (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_mul_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_cnt < CNT_W'(GAIN_W)))
        else $error("multiply step count out of range");

    a_xfer_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_LOAD) || (r_state == ST_DONE))
        else $error("accepted item did not start work");

    a_duty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_duty <= PWM_W'(PWM_FULL_SCALE)) &&
            (!r_clamped || r_duty == '0 || r_duty == PWM_W'(PWM_FULL_SCALE)))
        else $error("duty and clamp flag disagree");

endmodule

`default_nettype wire
